// ===== rtl/clen_pkg.sv =====
// shared constants and types for the content-length deframer
`timescale 1ns / 1ps

package clen_pkg;

    // width of the parsed body length
    localparam int LENGTH_BITS = 32;

    // header marker text
    localparam int MARKER_LEN = 16;
    localparam logic [7:0] MARKER_TEXT [MARKER_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    // special characters
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // number of bytes in the CR LF CR LF delimiter
    localparam logic [2:0] DELIM_LEN   = 3'd4;

    // header parser result toward the body counter
    typedef struct packed {
        logic                   body_start;
        logic [LENGTH_BITS-1:0] body_len;
    } t_hdr_result;

endpackage

// ===== rtl/content_length_deframer.sv =====
// top level: splits a byte stream into content-length framed bodies
// a body byte appears on the output in the cycle after its input beat is taken
// throughput: one byte per cycle if unstalled, set by the single output register
// header bytes and the delimiter produce no output beat
// reset: synchronous active-low, returns to header mode with all counters cleared
`timescale 1ns / 1ps

module content_length_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_body_byte,
    output logic       o_first_of_body,
    output logic       o_last_of_body
);
    import clen_pkg::*;

    logic                   r_in_body, n_in_body;
    logic                   r_body_started, n_body_started;
    logic [LENGTH_BITS-1:0] r_remaining, n_remaining;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_body_byte;
    logic                   r_first, r_last;

    logic                   accept;
    logic                   is_last;
    t_hdr_result            hdr_result;

    // take a new beat whenever the output register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_last    = (r_remaining <= LENGTH_BITS'(1));

    clen_hdr_parser u_hdr_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept && !r_in_body),
        .i_byte   (i_in_byte),
        .o_result (hdr_result)
    );

    // body counter and output handshake
    always_comb begin
        n_in_body      = r_in_body;
        n_body_started = r_body_started;
        n_remaining    = r_remaining;
        n_out_valid    = r_out_valid && !i_out_ready;
        if (accept) begin
            if (r_in_body) begin
                n_out_valid    = 1'b1;
                n_body_started = 1'b1;
                if (is_last) begin
                    n_remaining    = '0;
                    n_in_body      = 1'b0;
                    n_body_started = 1'b0;
                end else begin
                    n_remaining = r_remaining - LENGTH_BITS'(1);
                end
            end else if (hdr_result.body_start) begin
                n_in_body      = 1'b1;
                n_remaining    = hdr_result.body_len;
                n_body_started = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body      <= 1'b0;
            r_body_started <= 1'b0;
            r_remaining    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_in_body      <= n_in_body;
            r_body_started <= n_body_started;
            r_remaining    <= n_remaining;
            r_out_valid    <= n_out_valid;
        end
    end

    // output payload register, loaded on each body beat
    always_ff @(posedge i_clk) begin
        if (accept && r_in_body) begin
            r_body_byte <= i_in_byte;
            r_first     <= !r_body_started;
            r_last      <= is_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_body_byte     = r_body_byte;
    assign o_first_of_body = r_first;
    assign o_last_of_body  = r_last;

endmodule

// ===== rtl/clen_hdr_parser.sv =====
// header parser: marker match, decimal length, blank-line delimiter
`timescale 1ns / 1ps

module clen_hdr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_byte,
    output clen_pkg::t_hdr_result o_result
);
    import clen_pkg::*;

    logic [3:0]             r_marker_matched, n_marker_matched;
    logic                   r_marker_found, n_marker_found;
    logic                   r_digits_done, n_digits_done;
    logic                   r_overflow, n_overflow;
    logic [LENGTH_BITS-1:0] r_accum, n_accum;
    logic [1:0]             r_delim, n_delim;

    logic [4:0]             m_next;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [LENGTH_BITS+3:0] times_ten;
    logic [LENGTH_BITS+3:0] accum_next;
    logic                   want_cr;
    logic [2:0]             s_next;
    logic [LENGTH_BITS-1:0] len;

    assign is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
    assign digit    = 4'(i_byte - CHAR_ZERO);

    // accum * 10 + digit, with room to see overflow
    assign times_ten  = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1);
    assign accum_next = times_ten + {{LENGTH_BITS{1'b0}}, digit};

    always_comb begin
        n_marker_matched = r_marker_matched;
        n_marker_found   = r_marker_found;
        n_digits_done    = r_digits_done;
        n_overflow       = r_overflow;
        n_accum          = r_accum;
        n_delim          = r_delim;
        m_next           = 5'd0;
        s_next           = 3'd0;
        len              = '0;
        o_result         = '0;

        // marker tracking, then digits after it
        if (!r_marker_found) begin
            if (i_byte == MARKER_TEXT[r_marker_matched]) begin
                m_next = {1'b0, r_marker_matched} + 5'd1;
            end else if (i_byte == MARKER_TEXT[0]) begin
                m_next = 5'd1;
            end else begin
                m_next = 5'd0;
            end
            if (m_next == 5'(MARKER_LEN)) begin
                n_marker_found   = 1'b1;
                n_marker_matched = 4'd0;
            end else begin
                n_marker_matched = m_next[3:0];
            end
        end else if (!r_digits_done) begin
            if (is_digit) begin
                if (!r_overflow) begin
                    if (accum_next[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                        n_overflow = 1'b1;
                    end else begin
                        n_accum = accum_next[LENGTH_BITS-1:0];
                    end
                end
            end else begin
                n_digits_done = 1'b1;
            end
        end

        // delimiter CR LF CR LF
        want_cr = (r_delim == 2'd0) || (r_delim == 2'd2);
        if ((want_cr && i_byte == CHAR_CR) || (!want_cr && i_byte == CHAR_LF)) begin
            s_next = {1'b0, r_delim} + 3'd1;
        end else if (i_byte == CHAR_CR) begin
            s_next = 3'd1;
        end else begin
            s_next = 3'd0;
        end

        if (s_next == DELIM_LEN) begin
            len = (r_marker_found && !r_overflow) ? r_accum : '0;
            o_result.body_start = i_en && (len != '0);
            o_result.body_len   = len;
            n_marker_matched    = 4'd0;
            n_marker_found      = 1'b0;
            n_digits_done       = 1'b0;
            n_overflow          = 1'b0;
            n_accum             = '0;
            n_delim             = 2'd0;
        end else begin
            n_delim = s_next[1:0];
        end
    end

    // header state registers, updated on each header beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_matched <= 4'd0;
            r_marker_found   <= 1'b0;
            r_digits_done    <= 1'b0;
            r_overflow       <= 1'b0;
            r_accum          <= '0;
            r_delim          <= 2'd0;
        end else if (i_en) begin
            r_marker_matched <= n_marker_matched;
            r_marker_found   <= n_marker_found;
            r_digits_done    <= n_digits_done;
            r_overflow       <= n_overflow;
            r_accum          <= n_accum;
            r_delim          <= n_delim;
        end
    end

endmodule

// ===== verif/content_length_deframer_tb.sv =====
// testbench for the content-length deframer: framed messages, odd headers and raw noise
`timescale 1ns / 1ps

module content_length_deframer_tb;
    import clen_pkg::*;

    // one expected body beat
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } t_body_beat;

    typedef logic [LENGTH_BITS+3:0] t_wide_len;

    typedef enum {MSG_FRAMED, MSG_ZERO_LENGTH, MSG_NOISE, MSG_BROKEN} t_msg_kind;
    typedef enum {RDY_ALWAYS, RDY_MOSTLY, RDY_SELDOM, RDY_PERIODIC} t_ready_mode;

    // mirrors the deframer state and holds the body beats still to come
    class body_scoreboard;
        bit                     parsing_body;
        int unsigned            crlf_count;
        int unsigned            marker_pos;
        bit                     marker_seen;
        bit                     digits_ended;
        bit                     len_too_big;
        logic [LENGTH_BITS-1:0] len_value;
        logic [LENGTH_BITS-1:0] body_left;
        bit                     body_begun;
        t_body_beat             expected_q[$];
        int                     fail_count;

        function new();
            parsing_body = 0;
            body_left    = '0;
            body_begun   = 0;
            fail_count   = 0;
            clear_header();
        endfunction

        function void clear_header();
            crlf_count   = 0;
            marker_pos   = 0;
            marker_seen  = 0;
            digits_ended = 0;
            len_too_big  = 0;
            len_value    = '0;
        endfunction

        // accepted input beat: advance the parser, queue a body beat if one follows
        function void note_stream_byte(logic [7:0] b);
            int unsigned            m;
            bit                     want_cr;
            t_wide_len              wide;
            logic [LENGTH_BITS-1:0] len;
            t_body_beat             beat;

            if (parsing_body) begin
                beat.data  = b;
                beat.first = !body_begun;
                beat.last  = (body_left <= 1);
                expected_q.push_back(beat);
                body_begun = 1;
                if (body_left <= 1) begin
                    body_left    = '0;
                    parsing_body = 0;
                    body_begun   = 0;
                    clear_header();
                end else begin
                    body_left--;
                end
                return;
            end

            // marker search, then digit accumulation after the first marker
            if (!marker_seen) begin
                m = marker_pos;
                if (b == MARKER_TEXT[m])
                    m++;
                else
                    m = (b == MARKER_TEXT[0]) ? 1 : 0;
                if (m == MARKER_LEN) begin
                    marker_seen = 1;
                    marker_pos  = 0;
                end else begin
                    marker_pos = m;
                end
            end else if (!digits_ended) begin
                if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    if (!len_too_big) begin
                        wide = t_wide_len'(len_value) * 10 + t_wide_len'(b - CHAR_ZERO);
                        if (wide > t_wide_len'({LENGTH_BITS{1'b1}}))
                            len_too_big = 1;
                        else
                            len_value = wide[LENGTH_BITS-1:0];
                    end
                end else begin
                    digits_ended = 1;
                end
            end

            // blank-line delimiter, a stray cr restarts the match
            want_cr = (crlf_count == 0 || crlf_count == 2);
            if ((want_cr && b == CHAR_CR) || (!want_cr && b == CHAR_LF))
                crlf_count++;
            else
                crlf_count = (b == CHAR_CR) ? 1 : 0;
            if (crlf_count >= DELIM_LEN) begin
                len = (marker_seen && !len_too_big) ? len_value : '0;
                clear_header();
                if (len != 0) begin
                    parsing_body = 1;
                    body_left    = len;
                    body_begun   = 0;
                end
            end
        endfunction

        // output beat: compare against the oldest expected body beat
        function void check_body_beat(logic [7:0] data, logic first, logic last);
            t_body_beat want;

            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected body beat: data=%02h first=%0b last=%0b",
                             data, first, last);
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.data || first !== want.first || last !== want.last) begin
                fail_count++;
                if (fail_count <= 10)
                    $display({"body beat mismatch: exp data=%02h first=%0b last=%0b,",
                              " act data=%02h first=%0b last=%0b"},
                             want.data, want.first, want.last, data, first, last);
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_body_byte;
    logic       o_first_of_body;
    logic       o_last_of_body;

    body_scoreboard book = new();
    int bytes_sent = 0;
    int burst_left = 0;
    int hold_left  = 0;

    content_length_deframer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_body_byte     (o_body_byte),
        .o_first_of_body (o_first_of_body),
        .o_last_of_body  (o_last_of_body)
    );

    always #4 i_clk = ~i_clk;

    // run limit
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_body_beat(o_body_byte, o_first_of_body, o_last_of_body);
    end

    // receiver: changing ready patterns, plus long hold-offs on request
    initial begin : receiver
        t_ready_mode mode;
        int          span;
        int          phase;

        i_out_ready = 1'b0;
        mode  = RDY_ALWAYS;
        span  = 0;
        phase = 0;
        forever begin
            @(negedge i_clk);
            if (span == 0) begin
                mode = t_ready_mode'($urandom_range(0, 3));
                span = $urandom_range(20, 120);
            end
            span--;
            phase++;
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                case (mode)
                    RDY_ALWAYS:   i_out_ready = 1'b1;
                    RDY_MOSTLY:   i_out_ready = ($urandom_range(0, 9) < 7);
                    RDY_SELDOM:   i_out_ready = ($urandom_range(0, 9) < 3);
                    RDY_PERIODIC: i_out_ready = (phase % 4 != 0);
                    default:      i_out_ready = 1'b1;
                endcase
            end
        end
    end

    // offer one stream byte, in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;

        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_stream_byte(b);
        bytes_sent++;
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic send_body(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // printable filler for header lines
    task automatic send_junk(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
    endtask

    task automatic send_message(input int n);
        send_text("Content-Length: ");
        send_text($sformatf("%0d", n));
        send_crlf();
        send_crlf();
        send_body(n);
    endtask

    task automatic send_random_message();
        t_msg_kind kind;
        int        pick;
        int        len;

        pick = $urandom_range(0, 19);
        kind = (pick < 13) ? MSG_FRAMED :
               (pick < 16) ? MSG_ZERO_LENGTH :
               (pick < 18) ? MSG_NOISE : MSG_BROKEN;
        case (kind)
            MSG_FRAMED: begin
                if ($urandom_range(0, 2) == 0) begin
                    send_junk($urandom_range(1, 8));
                    send_crlf();
                end
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                send_text("Content-Length: ");
                if ($urandom_range(0, 4) == 0)
                    send_text("00");
                send_text($sformatf("%0d", len));
                if ($urandom_range(0, 3) == 0) begin
                    send_text(";");
                    send_junk($urandom_range(0, 5));
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_crlf();
                    send_junk($urandom_range(1, 8));
                end
                send_crlf();
                send_crlf();
                send_body(len);
            end
            MSG_ZERO_LENGTH: begin
                case ($urandom_range(0, 2))
                    0: send_junk($urandom_range(1, 10));
                    1: send_text("Content-Length: ");
                    default: begin
                        send_text("Content-Length: 9");
                        for (int i = 0; i < 10; i++)
                            send_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
                    end
                endcase
                send_crlf();
                send_crlf();
            end
            MSG_NOISE: begin
                send_body($urandom_range(1, 10));
            end
            default: begin
                // header that never completes, ended on a non-digit
                if ($urandom_range(0, 1) == 0) begin
                    send_text($sformatf("Content-Length: %0d;", $urandom_range(1, 9)));
                end else begin
                    send_crlf();
                    send_byte(CHAR_CR);
                    send_text("x");
                end
            end
        endcase
    endtask

    initial begin : stimulus
        int start;
        int msg_count;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = 8'h00;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // one-byte body: first and last together
        send_text("Content-Length: 1");
        send_crlf();
        send_crlf();
        send_byte(8'hFF);
        // zero length, missing marker, marker with no digits, overflow
        send_message(0);
        send_text("Host: x");
        send_crlf();
        send_crlf();
        send_text("Content-Length: ");
        send_crlf();
        send_crlf();
        send_text("Content-Length: 4294967296");
        send_crlf();
        send_crlf();
        // repeated marker: the first one wins
        send_text("Content-Length: 3");
        send_crlf();
        send_text("Content-Length: 9");
        send_crlf();
        send_crlf();
        send_byte(8'h00);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // partial marker and partial delimiter restarts, body holding a delimiter
        send_text("CContent-Length: 4");
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_crlf();
        send_crlf();
        // random sixteen-byte body, leading zero, digits stopped by junk
        send_message(16);
        send_text("Content-Length: 07");
        send_crlf();
        send_crlf();
        send_body(7);
        send_text("Content-Length: 2x5");
        send_crlf();
        send_crlf();
        send_body(2);

        // random messages, with long receiver hold-offs along the way
        start     = bytes_sent;
        msg_count = 0;
        while (bytes_sent - start < 290) begin
            if (msg_count == 1 || msg_count == 6) begin
                hold_left = $urandom_range(200, 400);
                send_message(30);
            end
            send_random_message();
            msg_count++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (book.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (book.fail_count == 0 && book.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== content_length_deframer.f =====
rtl/clen_pkg.sv
rtl/clen_hdr_parser.sv
rtl/content_length_deframer.sv
verif/content_length_deframer_tb.sv
